// ===== rtl/core/skd_pkg.sv =====
package skd_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned TARGET_W = 16;
    localparam int unsigned THR_W    = 12;
    localparam int unsigned CODE_W   = 2;

    // Largest speed sample, used to size the window sums
    localparam int unsigned SAMPLE_MAX = 4095;

    // Targets of zero or above this value stop the motor
    localparam int unsigned TARGET_MAX = 4096;

    // Default window lengths
    localparam int unsigned SHORT_LEN_DEF = 10;
    localparam int unsigned TREND_LEN_DEF = 4;

    // Register reset values
    localparam logic [THR_W-1:0] FAST_THR_RST = 12'd100;
    localparam logic [THR_W-1:0] ACT_THR_RST  = 12'd50;

    // Configuration register indexes
    localparam logic CFG_FAST_THR = 1'b0;
    localparam logic CFG_ACT_THR  = 1'b1;

    // Motor mode codes as reported on the result channel
    localparam logic [CODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [CODE_W-1:0] MODE_INIT     = 2'd1;
    localparam logic [CODE_W-1:0] MODE_STARTING = 2'd2;
    localparam logic [CODE_W-1:0] MODE_RUNNING  = 2'd3;

    // Indicator request codes
    localparam logic [CODE_W-1:0] IND_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] IND_BOTH  = 2'd1;
    localparam logic [CODE_W-1:0] IND_GREEN = 2'd2;
    localparam logic [CODE_W-1:0] IND_RED   = 2'd3;

    typedef enum logic [3:0] {
        ST_OFF   = 4'b0001,
        ST_INIT  = 4'b0010,
        ST_START = 4'b0100,
        ST_RUN   = 4'b1000
    } skd_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] motor_mode;
        logic [CODE_W-1:0] led_request;
        logic              kickback;
        logic              clear_target_request;
    } skd_result_t;

endpackage

// ===== rtl/core/saw_kickback_detector_core.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser: new_target_valid
//                                         s_tdata: new_target, speed_sample
// m_        out        m_tvalid/m_tready  m_tdata: motor_mode, led_request,
//                                         kickback, clear_target_request
// cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata
//
// One item per cycle sustained while m_tready is high; m_tvalid rises once the
// item reaches the result register; mode logic and running sums settle in one pass.
// aresetn is synchronous, active low: clears mode, target and both windows,
// and restores the thresholds to fast change 100, activation 50.
// A stalled m_tready holds the result register and one more item in the input
// register; s_tready then drops until the result is taken.
module saw_kickback_detector_core #(
    parameter int unsigned SHORT_LEN = skd_pkg::SHORT_LEN_DEF,
    parameter int unsigned TREND_LEN = skd_pkg::TREND_LEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [15:0] new_target, [27:16] speed_sample
    input  logic [0:0]                 s_tuser,   // [0] new_target_valid

    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [1:0] motor_mode, [3:2] led_request,
                                                  // [4] kickback, [5] clear_target_request

    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [skd_pkg::THR_W-1:0]  cfg_wdata
);

    logic                          in_valid_reg;
    logic                          tgt_valid_reg;
    logic [skd_pkg::TARGET_W-1:0]  tgt_reg;
    logic [skd_pkg::SAMPLE_W-1:0]  smp_reg;

    logic                          out_valid_reg;
    skd_pkg::skd_result_t          out_reg;

    logic [skd_pkg::THR_W-1:0]     fast_thr_reg;
    logic [skd_pkg::THR_W-1:0]     act_thr_reg;

    logic                          advance;
    logic                          push_req;
    logic                          trip;
    skd_pkg::skd_result_t          res;

    // Advance the held item into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register: capture a new item, or drop the slot once it advanced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tgt_valid_reg <= s_tuser[0];
            tgt_reg       <= s_tdata[15:0];
            smp_reg       <= s_tdata[27:16];
        end
    end

    // The user must write thresholds only while the block is idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_thr_reg <= skd_pkg::FAST_THR_RST;
            act_thr_reg  <= skd_pkg::ACT_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                skd_pkg::CFG_FAST_THR: fast_thr_reg <= cfg_wdata;
                skd_pkg::CFG_ACT_THR:  act_thr_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Mode sequencing and the indicator, kickback and clear requests
    skd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .tgt_valid (tgt_valid_reg),
        .tgt       (tgt_reg),
        .sample    (smp_reg),
        .act_thr   (act_thr_reg),
        .trip      (trip),
        .push      (push_req),
        .res       (res)
    );

    // Sample window, window of sums and the trip compare; shift only in
    // starting and running, and only when the item actually moves on
    skd_window #(
        .SHORT_LEN (SHORT_LEN),
        .TREND_LEN (TREND_LEN)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (advance && push_req),
        .sample   (smp_reg),
        .fast_thr (fast_thr_reg),
        .trip     (trip)
    );

    // Result register: load on advance, hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.clear_target_request,
                       out_reg.kickback,
                       out_reg.led_request,
                       out_reg.motor_mode};

endmodule

// ===== rtl/core/skd_window.sv =====
module skd_window #(
    parameter int unsigned SHORT_LEN = skd_pkg::SHORT_LEN_DEF,
    parameter int unsigned TREND_LEN = skd_pkg::TREND_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [skd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [skd_pkg::THR_W-1:0]     fast_thr,
    output logic                          trip
);

    localparam int unsigned SUM_W = $clog2(SHORT_LEN * skd_pkg::SAMPLE_MAX + 1);
    localparam int unsigned SOS_W = $clog2(SHORT_LEN * TREND_LEN * skd_pkg::SAMPLE_MAX + 1);
    localparam int unsigned LIM_MULT = SHORT_LEN * TREND_LEN;

    logic [skd_pkg::SAMPLE_W-1:0] smp_reg [SHORT_LEN];
    logic [SUM_W-1:0]             avg_reg [TREND_LEN];
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;
    logic [SOS_W-1:0]             sos_reg;
    logic [SOS_W-1:0]             sos_next;
    logic [SOS_W-1:0]             scaled;
    logic [SOS_W-1:0]             diff;
    logic [SOS_W-1:0]             limit;

    // Running sums: drop the oldest entry, add the newest
    always_comb begin
        sum_next = sum_reg + SUM_W'(sample) - SUM_W'(smp_reg[0]);
        sos_next = sos_reg + SOS_W'(sum_next) - SOS_W'(avg_reg[0]);
        scaled   = SOS_W'(sum_next) * SOS_W'(TREND_LEN);
        if (sos_next >= scaled) begin
            diff = sos_next - scaled;
        end else begin
            diff = scaled - sos_next;
        end
        limit = SOS_W'(fast_thr) * SOS_W'(LIM_MULT);
        trip  = diff > limit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SHORT_LEN; i++) begin
                smp_reg[i] <= '0;
            end
            for (int i = 0; i < TREND_LEN; i++) begin
                avg_reg[i] <= '0;
            end
            sum_reg <= '0;
            sos_reg <= '0;
        end else if (push) begin
            for (int i = 0; i + 1 < SHORT_LEN; i++) begin
                smp_reg[i] <= smp_reg[i+1];
            end
            smp_reg[SHORT_LEN-1] <= sample;
            for (int i = 0; i + 1 < TREND_LEN; i++) begin
                avg_reg[i] <= avg_reg[i+1];
            end
            avg_reg[TREND_LEN-1] <= sum_next;
            sum_reg <= sum_next;
            sos_reg <= sos_next;
        end
    end

endmodule

// ===== rtl/core/skd_ctrl.sv =====
module skd_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          tgt_valid,
    input  logic [skd_pkg::TARGET_W-1:0]  tgt,
    input  logic [skd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [skd_pkg::THR_W-1:0]     act_thr,
    input  logic                          trip,
    output logic                          push,
    output skd_pkg::skd_result_t          res
);

    skd_pkg::skd_state_t state_reg;
    skd_pkg::skd_state_t state_next;
    skd_pkg::skd_state_t state_eff;
    logic [skd_pkg::TARGET_W-1:0] target_reg;
    logic [skd_pkg::TARGET_W-1:0] target_next;
    logic [skd_pkg::TARGET_W-1:0] smp_ext;
    logic [skd_pkg::TARGET_W-1:0] spd_err;
    logic                         stop;
    logic                         at_speed;

    always_comb begin
        target_next = tgt_valid ? tgt : target_reg;
        stop = (tgt == '0) ||
               ({1'b0, tgt} > (skd_pkg::TARGET_W + 1)'(skd_pkg::TARGET_MAX));
        if (tgt_valid) begin
            state_eff = stop ? skd_pkg::ST_OFF : skd_pkg::ST_INIT;
        end else begin
            state_eff = state_reg;
        end

        smp_ext = skd_pkg::TARGET_W'(sample);
        if (smp_ext >= target_next) begin
            spd_err = smp_ext - target_next;
        end else begin
            spd_err = target_next - smp_ext;
        end
        at_speed = spd_err < skd_pkg::TARGET_W'(act_thr);

        push                     = 1'b0;
        state_next               = state_eff;
        res.led_request          = skd_pkg::IND_NONE;
        res.kickback             = 1'b0;
        res.clear_target_request = 1'b0;
        case (state_eff)
            skd_pkg::ST_INIT: begin
                res.led_request = skd_pkg::IND_BOTH;
                state_next      = skd_pkg::ST_START;
            end
            skd_pkg::ST_START: begin
                push = 1'b1;
                if (at_speed) begin
                    res.led_request = skd_pkg::IND_GREEN;
                    state_next      = skd_pkg::ST_RUN;
                end
            end
            skd_pkg::ST_RUN: begin
                push = 1'b1;
                if (trip) begin
                    res.led_request          = skd_pkg::IND_RED;
                    res.kickback             = 1'b1;
                    res.clear_target_request = 1'b1;
                    state_next               = skd_pkg::ST_OFF;
                end
            end
            default: begin
                state_next = skd_pkg::ST_OFF;
            end
        endcase

        case (state_next)
            skd_pkg::ST_START: res.motor_mode = skd_pkg::MODE_STARTING;
            skd_pkg::ST_RUN:   res.motor_mode = skd_pkg::MODE_RUNNING;
            skd_pkg::ST_INIT:  res.motor_mode = skd_pkg::MODE_INIT;
            default:           res.motor_mode = skd_pkg::MODE_OFF;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= skd_pkg::ST_OFF;
            target_reg <= '0;
        end else if (advance) begin
            state_reg  <= state_next;
            target_reg <= target_next;
        end
    end

endmodule

// ===== verif/tb_saw_kickback_detector_core.sv =====
`timescale 1ns / 1ps

module tb_saw_kickback_detector_core;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int WINDOW_N     = skd_pkg::SHORT_LEN_DEF;
    localparam int TREND_N      = skd_pkg::TREND_LEN_DEF;

    // One status word as it leaves the block, split into its fields.
    typedef struct {
        logic [skd_pkg::CODE_W-1:0] motor_mode;
        logic [skd_pkg::CODE_W-1:0] led_request;
        logic                       kickback;
        logic                       clear_target_request;
    } tick_status_t;

    // Tracks the speed supervisor: mode, target, both history windows and the
    // thresholds, and keeps the status words still owed by the block.
    class kickback_scoreboard;
        logic [skd_pkg::CODE_W-1:0]   mode;
        logic [skd_pkg::TARGET_W-1:0] target;
        logic [skd_pkg::SAMPLE_W-1:0] samples [WINDOW_N];
        logic [15:0]                  sums [TREND_N];
        logic [skd_pkg::THR_W-1:0]    fast_thr;
        logic [skd_pkg::THR_W-1:0]    act_thr;
        tick_status_t                 owed_status [$];
        int                           mismatches;

        function new();
            mode       = skd_pkg::MODE_OFF;
            target     = '0;
            fast_thr   = skd_pkg::FAST_THR_RST;
            act_thr    = skd_pkg::ACT_THR_RST;
            mismatches = 0;
            foreach (samples[i]) samples[i] = '0;
            foreach (sums[i]) sums[i] = '0;
        endfunction

        function void set_threshold(logic addr, logic [skd_pkg::THR_W-1:0] value);
            if (addr == skd_pkg::CFG_FAST_THR)
                fast_thr = value;
            else
                act_thr = value;
        endfunction

        // Shift the sample through both windows; report a fast speed change.
        function bit shift_windows(logic [skd_pkg::SAMPLE_W-1:0] smp);
            int total;
            int trend;
            int diff;
            total = 0;
            trend = 0;
            for (int i = 0; i < WINDOW_N - 1; i++) samples[i] = samples[i + 1];
            samples[WINDOW_N - 1] = smp;
            foreach (samples[i]) total += int'(samples[i]);
            for (int i = 0; i < TREND_N - 1; i++) sums[i] = sums[i + 1];
            sums[TREND_N - 1] = total[15:0];
            foreach (sums[i]) trend += int'(sums[i]);
            diff = trend - TREND_N * total;
            if (diff < 0) diff = -diff;
            return diff > WINDOW_N * TREND_N * int'(fast_thr);
        endfunction

        function void note_tick(bit tv, logic [skd_pkg::TARGET_W-1:0] tgt,
                                logic [skd_pkg::SAMPLE_W-1:0] smp);
            tick_status_t st;
            int spd_err;
            st.led_request          = skd_pkg::IND_NONE;
            st.kickback             = 1'b0;
            st.clear_target_request = 1'b0;
            if (tv) begin
                target = tgt;
                mode   = (tgt == 0 || tgt > skd_pkg::TARGET_MAX) ? skd_pkg::MODE_OFF
                                                                 : skd_pkg::MODE_INIT;
            end
            case (mode)
                skd_pkg::MODE_INIT: begin
                    st.led_request = skd_pkg::IND_BOTH;
                    mode           = skd_pkg::MODE_STARTING;
                end
                skd_pkg::MODE_STARTING: begin
                    void'(shift_windows(smp));
                    spd_err = int'(smp) - int'(target);
                    if (spd_err < 0) spd_err = -spd_err;
                    if (spd_err < int'(act_thr)) begin
                        st.led_request = skd_pkg::IND_GREEN;
                        mode           = skd_pkg::MODE_RUNNING;
                    end
                end
                skd_pkg::MODE_RUNNING: begin
                    if (shift_windows(smp)) begin
                        st.led_request          = skd_pkg::IND_RED;
                        st.kickback             = 1'b1;
                        st.clear_target_request = 1'b1;
                        mode                    = skd_pkg::MODE_OFF;
                    end
                end
                default: ;
            endcase
            st.motor_mode = mode;
            owed_status.push_back(st);
        endfunction

        function void check_status(logic [7:0] word);
            tick_status_t got;
            tick_status_t want;
            got.motor_mode           = word[1:0];
            got.led_request          = word[3:2];
            got.kickback             = word[4];
            got.clear_target_request = word[5];
            if (owed_status.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected status %h with nothing owed", word);
                return;
            end
            want = owed_status.pop_front();
            if (got.motor_mode !== want.motor_mode || got.led_request !== want.led_request ||
                got.kickback !== want.kickback ||
                got.clear_target_request !== want.clear_target_request) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("status mismatch: want m%0d l%0d k%0d c%0d, got m%0d l%0d k%0d c%0d",
                             want.motor_mode, want.led_request, want.kickback,
                             want.clear_target_request, got.motor_mode, got.led_request,
                             got.kickback, got.clear_target_request);
            end
        endfunction

        function int pending();
            return owed_status.size();
        endfunction
    endclass

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [31:0]                s_tdata   = '0;   // [15:0] new_target, [27:16] speed_sample
    logic [0:0]                 s_tuser   = '0;   // [0] new_target_valid
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [7:0]                 m_tdata;          // [1:0] motor_mode, [3:2] led_request,
                                                  // [4] kickback, [5] clear_target_request
    logic                       cfg_wr_en = 1'b0;
    logic                       cfg_addr  = 1'b0;
    logic [skd_pkg::THR_W-1:0]  cfg_wdata = '0;

    kickback_scoreboard status_board = new();
    bit src_calm   = 1'b0;
    bit snk_calm   = 1'b0;
    int cycle_count = 0;

    saw_kickback_detector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop: a hung handshake or a lost status word lands here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** saw_kickback_detector_core: FAILED **");
        $finish;
    end

    // Speed sample close to a level, clamped to the converter range.
    function automatic logic [skd_pkg::SAMPLE_W-1:0] speed_near(int level, int spread);
        int v;
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > int'(skd_pkg::SAMPLE_MAX)) v = int'(skd_pkg::SAMPLE_MAX);
        return v[skd_pkg::SAMPLE_W-1:0];
    endfunction

    // Any speed sample over the full converter range.
    function automatic logic [skd_pkg::SAMPLE_W-1:0] any_sample();
        int v;
        v = int'($urandom_range(0, skd_pkg::SAMPLE_MAX));
        return v[skd_pkg::SAMPLE_W-1:0];
    endfunction

    // Threshold drawn from a range.
    function automatic logic [skd_pkg::THR_W-1:0] any_thr(int lo, int hi);
        int v;
        v = int'($urandom_range(lo, hi));
        return v[skd_pkg::THR_W-1:0];
    endfunction

    // Present one tick after a random gap; hold it until the block takes it.
    // Every so often flip into or out of a stretch with no gaps at all.
    task automatic send_tick(input bit tv, input logic [skd_pkg::TARGET_W-1:0] tgt,
                             input logic [skd_pkg::SAMPLE_W-1:0] smp);
        int gap;
        if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tv;
        s_tdata  <= {4'b0, smp, tgt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_board.note_tick(tv, tgt, smp);
    endtask

    // Drop valid and hold off until every owed status word is back, then let
    // the pipeline empty. Thresholds are only touched from this quiet state.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (status_board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_thresholds(input logic [skd_pkg::THR_W-1:0] fast_thr,
                                      input logic [skd_pkg::THR_W-1:0] act_thr);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= skd_pkg::CFG_FAST_THR;
        cfg_wdata <= fast_thr;
        @(posedge aclk);
        cfg_addr  <= skd_pkg::CFG_ACT_THR;
        cfg_wdata <= act_thr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        status_board.set_threshold(skd_pkg::CFG_FAST_THR, fast_thr);
        status_board.set_threshold(skd_pkg::CFG_ACT_THR, act_thr);
    endtask

    // Mostly full start-up runs: a fresh target, an approach toward it, then
    // a stretch at speed with small ripple and the odd sudden jump that
    // should trip a kickback. The rest is raw noise and stop commands.
    task automatic run_sequences(input int n_ticks);
        int sent;
        int level;
        int hold;
        logic [skd_pkg::SAMPLE_W-1:0] smp;
        sent = 0;
        while (sent < n_ticks) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_tick(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                              any_sample());
                    sent++;
                end
                1: begin
                    // stop command: zero or beyond the top speed
                    send_tick(1'b1, $urandom_range(0, 1) ? 16'd0
                                    : 16'($urandom_range(skd_pkg::TARGET_MAX + 1, 16'hFFFF)),
                              any_sample());
                    sent++;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       level = 1;
                        1:       level = int'(skd_pkg::TARGET_MAX);
                        default: level = int'($urandom_range(1, skd_pkg::TARGET_MAX));
                    endcase
                    send_tick(1'b1, 16'(level), any_sample());
                    sent++;
                    hold = $urandom_range(1, 4);
                    for (int k = 0; k < hold; k++) begin
                        send_tick(1'b0, 16'($urandom()), speed_near(level, 150));
                        sent++;
                    end
                    hold = $urandom_range(8, 30);
                    for (int k = 0; k < hold; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            smp = any_sample();
                        else
                            smp = speed_near(level, 20);
                        send_tick(1'b0, 16'($urandom()), smp);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // Result side: random back-pressure per status word, with calm stretches.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
            stall = snk_calm ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Check every status word the block hands over.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            status_board.check_status(m_tdata);
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under the reset thresholds.
        send_tick(1'b0, 16'hFFFF, 12'hFFF);       // idle tick, data ignored while off
        send_tick(1'b1, 16'd0, 12'd0);            // zero target stops
        send_tick(1'b1, 16'd4097, 12'h800);       // just above top speed stops
        send_tick(1'b1, 16'hFFFF, 12'hFFF);       // largest target stops
        send_tick(1'b1, 16'(skd_pkg::TARGET_MAX), 12'd0);  // top speed starts, both LEDs
        send_tick(1'b0, 16'd0, 12'd0);            // far from target, keep starting
        send_tick(1'b0, 16'd0, 12'hFFF);          // one below target, at speed
        repeat (4) send_tick(1'b0, 16'd0, 12'hFFF);
        send_tick(1'b1, 16'd1, 12'd0);            // lowest target
        send_tick(1'b0, 16'd0, 12'd0);
        repeat (2) send_tick(1'b0, 16'd0, 12'd0);
        send_tick(1'b0, 16'd0, 12'hFFF);          // sudden jump
        send_tick(1'b1, 16'd2000, 12'd1990);      // restart, sample unused in init
        send_tick(1'b0, 16'd0, 12'd1990);
        send_tick(1'b1, 16'd0, 12'd1990);         // stop while running
        send_tick(1'b0, 16'd0, 12'd1990);         // off: windows stay frozen

        run_sequences(80);

        // Extremes: trip on any change, and reach speed on nearly every sample.
        settle();
        program_thresholds('0, '1);
        run_sequences(60);

        // Extremes: never trip, and never reach speed.
        settle();
        program_thresholds('1, '0);
        run_sequences(60);

        settle();
        program_thresholds(any_thr(0, int'(skd_pkg::SAMPLE_MAX)),
                           any_thr(0, int'(skd_pkg::SAMPLE_MAX)));
        run_sequences(80);

        settle();
        program_thresholds(any_thr(20, 200), any_thr(30, 120));
        run_sequences(120);

        // Drain whatever is still owed, then let the pipe empty.
        settle();
        if (status_board.mismatches == 0 && status_board.pending() == 0)
            $display("** saw_kickback_detector_core: PASSED **");
        else
            $display("** saw_kickback_detector_core: FAILED **");
        $finish;
    end

endmodule
